// ----- rtl/rrts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types, constants and helpers of the round-robin thread scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int SLOTS   = 8;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FIELD_W = 3;
  localparam int REQ_W   = 3;
  localparam int Q_W     = 8;
  localparam int ID_W    = 16;

  localparam logic [Q_W-1:0]  QUANTUM_RESET = Q_W'(2);
  localparam logic [ID_W-1:0] ID_RESET      = ID_W'(1);

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK   = 3'd0,
    REQ_YIELD  = 3'd1,
    REQ_BLOCK  = 3'd2,
    REQ_WAKE   = 3'd3,
    REQ_EXIT   = 3'd4,
    REQ_CREATE = 3'd5
  } req_e;

  typedef enum logic [2:0] {
    ST_UNUSED   = 3'd0,
    ST_READY    = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_BLOCKED  = 3'd3,
    ST_SLEEPING = 3'd4
  } slot_state_e;

  typedef struct packed {
    slot_state_e st;
    logic        wake;
    logic        parked;
  } entry_t;

  typedef enum logic [1:0] {
    A_CUR,
    A_PTR,
    A_TGT,
    A_NX
  } addr_sel_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_QL_DEC,
    OP_QL_RELOAD,
    OP_SCAN_INIT,
    OP_SCAN_STEP,
    OP_CHK_CUR,
    OP_CONSUME,
    OP_BLOCK_CUR,
    OP_UNBLOCK_CUR,
    OP_WAKE,
    OP_EXIT_CUR,
    OP_HALT,
    OP_SWITCH_OLD,
    OP_SWITCH_NEW,
    OP_CSCAN_INIT,
    OP_CSCAN_STEP
  } dp_op_e;

  typedef struct packed {
    dp_op_e    op;
    addr_sel_e addr;
    logic      park;
  } dp_cmd_t;

  typedef struct packed {
    req_e        req;
    logic        halted;
    logic        ql_zero;
    logic        tgt_ok;
    slot_state_e rd_st;
    logic        rd_wake;
    logic        scan_last;
    logic        ptr_last;
    logic        found;
    logic        nx_is_cur;
  } dp_status_t;

  function automatic logic [FIELD_W-1:0] slot_field(input logic [SLOT_W-1:0] s);
    logic [SLOT_W+FIELD_W-1:0] w;
    w = {{FIELD_W{1'b0}}, s};
    return w[FIELD_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(SLOTS - 1)) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

endpackage

// ----- rtl/rrts_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_dp
// Slot table, scan pointer, quantum and id counters, and result registers.
// ----------------------------------------------------------------------------
module rrts_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rrts_pkg::Q_W-1:0]      cfg_wdata_i,
  input  logic [rrts_pkg::REQ_W-1:0]    req_type_i,
  input  logic [rrts_pkg::FIELD_W-1:0]  target_slot_i,
  input  rrts_pkg::dp_cmd_t             cmd_i,
  output rrts_pkg::dp_status_t          status_o,
  output logic [rrts_pkg::FIELD_W-1:0]  running_slot_o,
  output logic                          switched_o,
  output logic [rrts_pkg::FIELD_W-1:0]  previous_slot_o,
  output logic                          resumed_from_block_o,
  output logic                          wake_consumed_o,
  output logic                          create_ok_o,
  output logic [rrts_pkg::FIELD_W-1:0]  created_slot_o,
  output logic [rrts_pkg::ID_W-1:0]     created_id_o,
  output logic                          halted_o
);
  import rrts_pkg::*;

  localparam int TW = SLOT_W + FIELD_W;

  entry_t              tbl_q [SLOTS];
  logic [SLOT_W-1:0]   cur_q, prev_q, ptr_q, cnt_q, nx_q;
  logic [Q_W-1:0]      ql_q, qt_q;
  logic [ID_W-1:0]     id_q, cid_q;
  logic                halt_q, found_q;
  logic                resumed_q, consumed_q, cok_q;
  logic [SLOT_W-1:0]   cslot_q;
  req_e                req_q;
  logic [FIELD_W-1:0]  tgt_q;

  logic [TW-1:0]       tgt_wide;
  logic                tgt_ok;
  logic [SLOT_W-1:0]   tgt_idx;
  logic [SLOT_W-1:0]   rd_addr;
  entry_t              rd;
  entry_t              wr_data;
  logic                wr_en;
  logic                scan_init;

  assign tgt_wide = {{SLOT_W{1'b0}}, tgt_q};
  assign tgt_ok   = (tgt_wide < TW'(SLOTS));
  assign tgt_idx  = tgt_wide[SLOT_W-1:0];

  always_comb begin
    case (cmd_i.addr)
      A_CUR:   rd_addr = cur_q;
      A_PTR:   rd_addr = ptr_q;
      A_TGT:   rd_addr = tgt_idx;
      A_NX:    rd_addr = nx_q;
      default: rd_addr = cur_q;
    endcase
  end

  assign rd = tbl_q[rd_addr];

  assign scan_init = (cmd_i.op == OP_QL_RELOAD) || (cmd_i.op == OP_SCAN_INIT) ||
                     (cmd_i.op == OP_BLOCK_CUR) || (cmd_i.op == OP_EXIT_CUR);

  always_comb begin
    wr_en   = 1'b0;
    wr_data = rd;
    case (cmd_i.op)
      OP_CONSUME: begin
        wr_en        = 1'b1;
        wr_data.wake = 1'b0;
      end
      OP_BLOCK_CUR: begin
        wr_en      = 1'b1;
        wr_data.st = ST_BLOCKED;
      end
      OP_UNBLOCK_CUR: begin
        wr_en        = 1'b1;
        wr_data.st   = ST_RUNNING;
        wr_data.wake = 1'b0;
      end
      OP_WAKE: begin
        wr_en        = 1'b1;
        wr_data.wake = 1'b1;
        if (rd.st == ST_BLOCKED || rd.st == ST_SLEEPING) begin
          wr_data.st = ST_READY;
        end
      end
      OP_EXIT_CUR: begin
        wr_en      = 1'b1;
        wr_data.st = ST_UNUSED;
      end
      OP_SWITCH_OLD: begin
        wr_en = 1'b1;
        if (rd.st == ST_RUNNING) begin
          wr_data.st = ST_READY;
        end
        if (cmd_i.park) begin
          wr_data.parked = 1'b1;
        end
      end
      OP_SWITCH_NEW: begin
        wr_en      = 1'b1;
        wr_data.st = ST_RUNNING;
        if (rd.parked) begin
          wr_data.parked = 1'b0;
          wr_data.wake   = 1'b0;
        end
      end
      OP_CSCAN_STEP: begin
        if (rd.st == ST_UNUSED) begin
          wr_en          = 1'b1;
          wr_data.st     = ST_READY;
          wr_data.wake   = 1'b0;
          wr_data.parked = 1'b0;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // slot table and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        tbl_q[i].st     <= (i == 0) ? ST_RUNNING : ST_UNUSED;
        tbl_q[i].wake   <= 1'b0;
        tbl_q[i].parked <= 1'b0;
      end
      cur_q  <= '0;
      ql_q   <= QUANTUM_RESET;
      qt_q   <= QUANTUM_RESET;
      id_q   <= ID_RESET;
      halt_q <= 1'b0;
    end else begin
      if (wr_en) begin
        tbl_q[rd_addr] <= wr_data;
      end
      if (cfg_we_i) begin
        qt_q <= cfg_wdata_i;
      end
      if (cmd_i.op == OP_QL_DEC) begin
        ql_q <= ql_q - 1'b1;
      end
      if (cmd_i.op == OP_QL_RELOAD) begin
        ql_q <= qt_q;
      end
      if (cmd_i.op == OP_HALT) begin
        halt_q <= 1'b1;
      end
      if (cmd_i.op == OP_SWITCH_NEW) begin
        cur_q <= nx_q;
      end
      if (cmd_i.op == OP_CSCAN_STEP && rd.st == ST_UNUSED) begin
        id_q <= id_q + 1'b1;
      end
    end
  end

  // per-word working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_CAPTURE) begin
      req_q      <= req_e'(req_type_i);
      tgt_q      <= target_slot_i;
      prev_q     <= cur_q;
      resumed_q  <= 1'b0;
      consumed_q <= 1'b0;
      cok_q      <= 1'b0;
      cslot_q    <= '0;
      cid_q      <= '0;
    end
    if (scan_init) begin
      ptr_q   <= slot_inc(cur_q);
      cnt_q   <= '0;
      found_q <= 1'b0;
    end
    if (cmd_i.op == OP_SCAN_STEP) begin
      ptr_q <= slot_inc(ptr_q);
      cnt_q <= cnt_q + 1'b1;
      if (rd.st == ST_READY) begin
        found_q <= 1'b1;
        nx_q    <= ptr_q;
      end
    end
    if (cmd_i.op == OP_CHK_CUR && rd.st == ST_RUNNING) begin
      found_q <= 1'b1;
      nx_q    <= cur_q;
    end
    if (cmd_i.op == OP_CONSUME) begin
      consumed_q <= 1'b1;
    end
    if (cmd_i.op == OP_SWITCH_NEW && rd.parked) begin
      resumed_q <= 1'b1;
    end
    if (cmd_i.op == OP_CSCAN_INIT) begin
      ptr_q <= '0;
    end
    if (cmd_i.op == OP_CSCAN_STEP) begin
      ptr_q <= slot_inc(ptr_q);
      if (rd.st == ST_UNUSED) begin
        cok_q   <= 1'b1;
        cslot_q <= ptr_q;
        cid_q   <= id_q;
      end
    end
  end

  assign status_o.req       = req_q;
  assign status_o.halted    = halt_q;
  assign status_o.ql_zero   = (ql_q == '0);
  assign status_o.tgt_ok    = tgt_ok;
  assign status_o.rd_st     = rd.st;
  assign status_o.rd_wake   = rd.wake;
  assign status_o.scan_last = (cnt_q == SLOT_W'(SLOTS - 1));
  assign status_o.ptr_last  = (ptr_q == SLOT_W'(SLOTS - 1));
  assign status_o.found     = found_q;
  assign status_o.nx_is_cur = (nx_q == cur_q);

  assign running_slot_o       = slot_field(cur_q);
  assign switched_o           = (cur_q != prev_q);
  assign previous_slot_o      = slot_field(prev_q);
  assign resumed_from_block_o = resumed_q;
  assign wake_consumed_o      = consumed_q;
  assign create_ok_o          = cok_q;
  assign created_slot_o       = slot_field(cslot_q);
  assign created_id_o         = cid_q;
  assign halted_o             = halt_q;

endmodule

// ----- rtl/rrts_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_ctrl
// Sequencer: steps one event through dispatch, slot or create scan, switch and output.
// ----------------------------------------------------------------------------
module rrts_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  rrts_pkg::dp_status_t status_i,
  output rrts_pkg::dp_cmd_t    cmd_o
);
  import rrts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_CHK,
    S_DECIDE,
    S_SWOLD,
    S_SWNEW,
    S_CSCAN,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   stall_q, stall_d;
  logic   ovalid_q, ovalid_d;

  always_comb begin
    state_d    = state_q;
    stall_d    = stall_q;
    ovalid_d   = ovalid_q;
    cmd_o.op   = OP_NONE;
    cmd_o.addr = A_CUR;
    cmd_o.park = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_CAPTURE;
          stall_d  = 1'b1;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd_o.addr = (status_i.req == REQ_WAKE) ? A_TGT : A_CUR;
        state_d    = S_OUT;
        if (!status_i.halted) begin
          case (status_i.req)
            REQ_TICK: begin
              if (!status_i.ql_zero) begin
                cmd_o.op = OP_QL_DEC;
              end else begin
                cmd_o.op = OP_QL_RELOAD;
                state_d  = S_SCAN;
              end
            end
            REQ_YIELD: begin
              cmd_o.op = OP_SCAN_INIT;
              state_d  = S_SCAN;
            end
            REQ_BLOCK: begin
              if (status_i.rd_wake) begin
                cmd_o.op = OP_CONSUME;
              end else begin
                cmd_o.op = OP_BLOCK_CUR;
                state_d  = S_SCAN;
              end
            end
            REQ_WAKE: begin
              if (status_i.tgt_ok) begin
                cmd_o.op = OP_WAKE;
              end
            end
            REQ_EXIT: begin
              cmd_o.op = OP_EXIT_CUR;
              state_d  = S_SCAN;
            end
            REQ_CREATE: begin
              cmd_o.op = OP_CSCAN_INIT;
              state_d  = S_CSCAN;
            end
            default: begin
              cmd_o.op = OP_NONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.addr = A_PTR;
        cmd_o.op   = OP_SCAN_STEP;
        if (status_i.rd_st == ST_READY) begin
          state_d = S_DECIDE;
        end else if (status_i.scan_last) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        cmd_o.op = OP_CHK_CUR;
        state_d  = S_DECIDE;
      end
      S_DECIDE: begin
        state_d = S_OUT;
        case (status_i.req)
          REQ_BLOCK: begin
            if (status_i.found) begin
              state_d = S_SWOLD;
            end else begin
              cmd_o.op = OP_UNBLOCK_CUR;
            end
          end
          REQ_EXIT: begin
            if (status_i.found) begin
              state_d = S_SWOLD;
            end else begin
              cmd_o.op = OP_HALT;
            end
          end
          default: begin
            if (status_i.found && !status_i.nx_is_cur) begin
              state_d = S_SWOLD;
            end
          end
        endcase
      end
      S_SWOLD: begin
        cmd_o.op   = OP_SWITCH_OLD;
        cmd_o.park = (status_i.req == REQ_BLOCK);
        state_d    = S_SWNEW;
      end
      S_SWNEW: begin
        cmd_o.addr = A_NX;
        cmd_o.op   = OP_SWITCH_NEW;
        state_d    = S_OUT;
      end
      S_CSCAN: begin
        cmd_o.addr = A_PTR;
        cmd_o.op   = OP_CSCAN_STEP;
        if (status_i.rd_st == ST_UNUSED || status_i.ptr_last) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d  = S_IDLE;
          stall_d  = 1'b0;
          ovalid_d = 1'b0;
        end
      end
      default: begin
        state_d  = S_IDLE;
        stall_d  = 1'b0;
        ovalid_d = 1'b0;
      end
    endcase
    if (state_d == S_OUT && state_q != S_OUT) begin
      ovalid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      stall_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      stall_q  <= stall_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_stall_o  = stall_q;
  assign out_valid_o = ovalid_q;

endmodule

// ----- rtl/round_robin_thread_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler
// Round-robin preemptive scheduler over a table of thread slots.
// ----------------------------------------------------------------------------
// Usage:
//   input channel carries one event word (req_type, target_slot) with
//   in_valid_i / in_stall_o; output channel carries one result word per
//   event with out_valid_o / out_stall_i.
//   events are handled one at a time. After the accept, dispatch goes to
//   the output state for tick-decrement, wake, consumed block, unknown codes
//   and any event once halted; events that scan for the next ready slot (one
//   slot table entry read per cycle) pass the scan, the check if none is
//   ready, the decide and, on a switch, the two switch states; create steps
//   through the create scan. A new event is taken in the cycle after its
//   result is taken. While a result waits, in_stall_o stays high and the
//   result holds. quantum_ticks is written through cfg_we_i / cfg_wdata_i;
//   the user must write it only while idle; the block does not enforce it.
//   Reset leaves slot 0 running, all other slots unused, quantum and
//   quantum_ticks at 2, next thread id 1, no halt; no clearing pass.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rrts_pkg::Q_W-1:0]      cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rrts_pkg::REQ_W-1:0]    req_type_i,
  input  logic [rrts_pkg::FIELD_W-1:0]  target_slot_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rrts_pkg::FIELD_W-1:0]  running_slot_o,
  output logic                          switched_o,
  output logic [rrts_pkg::FIELD_W-1:0]  previous_slot_o,
  output logic                          resumed_from_block_o,
  output logic                          wake_consumed_o,
  output logic                          create_ok_o,
  output logic [rrts_pkg::FIELD_W-1:0]  created_slot_o,
  output logic [rrts_pkg::ID_W-1:0]     created_id_o,
  output logic                          halted_o
);
  import rrts_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  rrts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rrts_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .req_type_i           (req_type_i),
    .target_slot_i        (target_slot_i),
    .cmd_i                (cmd),
    .status_o             (status),
    .running_slot_o       (running_slot_o),
    .switched_o           (switched_o),
    .previous_slot_o      (previous_slot_o),
    .resumed_from_block_o (resumed_from_block_o),
    .wake_consumed_o      (wake_consumed_o),
    .create_ok_o          (create_ok_o),
    .created_slot_o       (created_slot_o),
    .created_id_o         (created_id_o),
    .halted_o             (halted_o)
  );

endmodule

// ----- rtl/rrts_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_chk
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module rrts_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [rrts_pkg::FIELD_W-1:0]  running_slot_o,
  input logic                          switched_o,
  input logic [rrts_pkg::FIELD_W-1:0]  previous_slot_o,
  input logic                          resumed_from_block_o,
  input logic                          wake_consumed_o,
  input logic                          create_ok_o,
  input logic                          halted_o
);

  // a stalled result stays valid and its running slot holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(running_slot_o))
    else $error("stalled result word changed");

  // no new event is taken while a result is pending
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result pending");

  // result never shows in the cycle right after an accept
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o)
    else $error("result too early");

  // switch flag agrees with the slots reported; a consumed wake has no switch or resume
  a_switch_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (switched_o == (running_slot_o != previous_slot_o)) &&
                    !(wake_consumed_o && (switched_o || resumed_from_block_o)))
    else $error("switch flags inconsistent");

  // halted result carries no activity
  a_halted_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && halted_o && !$rose(halted_o) |->
      !switched_o && !create_ok_o && !wake_consumed_o && !resumed_from_block_o)
    else $error("activity reported while halted");

endmodule

bind round_robin_thread_scheduler rrts_chk u_rrts_chk (.*);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the round-robin thread scheduler. A queue of event
// words feeds a clocked driver; every accepted event is run through a local
// slot-table predictor and the expected result word is compared with the one
// the scheduler returns. Phases vary the quantum reload value and the idle /
// stall pressure on both channels, a create/exit run fills and empties the
// slot table, and the run ends with the scheduler halted.
// ----------------------------------------------------------------------------
module tb_top;
  import rrts_pkg::*;

  localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic [FIELD_W-1:0] tgt;
  } event_t;

  typedef struct packed {
    logic [SLOTS-1:0][2:0] st;
    logic [SLOTS-1:0]      wake;
    logic [SLOTS-1:0]      parked;
    logic [FIELD_W-1:0]    cur;
    logic [Q_W-1:0]        ql;
    logic [ID_W-1:0]       next_id;
    logic                  halt;
    logic [Q_W-1:0]        qticks;
  } sched_t;

  typedef struct packed {
    logic [FIELD_W-1:0] running;
    logic               switched;
    logic [FIELD_W-1:0] previous;
    logic               resumed;
    logic               consumed;
    logic               cok;
    logic [FIELD_W-1:0] cslot;
    logic [ID_W-1:0]    cid;
    logic               halted;
  } sched_out_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [Q_W-1:0]      cfg_wdata_i   = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic [REQ_W-1:0]    req_type_i    = '0;
  logic [FIELD_W-1:0]  target_slot_i = '0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [FIELD_W-1:0]  running_slot_o;
  logic                switched_o;
  logic [FIELD_W-1:0]  previous_slot_o;
  logic                resumed_from_block_o;
  logic                wake_consumed_o;
  logic                create_ok_o;
  logic [FIELD_W-1:0]  created_slot_o;
  logic [ID_W-1:0]     created_id_o;
  logic                halted_o;

  event_t     pending_events[$];
  sched_out_t expected_results[$];
  sched_t     table_state;
  sched_t     plan_state;
  event_t     next_word;
  sched_out_t seen_word;
  sched_out_t want_word;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int err_count     = 0;
  int n_results     = 0;
  int n_switch      = 0;
  int n_resume      = 0;
  int n_consume     = 0;
  int n_create      = 0;

  round_robin_thread_scheduler DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .req_type_i          (req_type_i),
    .target_slot_i       (target_slot_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .running_slot_o      (running_slot_o),
    .switched_o          (switched_o),
    .previous_slot_o     (previous_slot_o),
    .resumed_from_block_o(resumed_from_block_o),
    .wake_consumed_o     (wake_consumed_o),
    .create_ok_o         (create_ok_o),
    .created_slot_o      (created_slot_o),
    .created_id_o        (created_id_o),
    .halted_o            (halted_o)
  );

  always #10 clk_i = ~clk_i;

  // {found, slot}: first slot in the given state, scanning from start
  function automatic logic [FIELD_W:0] scan_for_state(input sched_t s, input logic [2:0] want,
                                                      input int start);
    logic [FIELD_W:0] r;
    int               k;
    int               idx;
    r = '0;
    for (k = 0; k < SLOTS; k++) begin
      idx = (start + k) % SLOTS;
      if (!r[FIELD_W] && s.st[idx] == want) begin
        r = {1'b1, FIELD_W'(idx)};
      end
    end
    return r;
  endfunction

  // {found, slot}: next ready slot after the current one, else current if running
  function automatic logic [FIELD_W:0] pick_next_ready(input sched_t s);
    logic [FIELD_W:0] r;
    r = scan_for_state(s, ST_READY, (int'(s.cur) + 1) % SLOTS);
    if (!r[FIELD_W] && s.st[s.cur] == ST_RUNNING) begin
      r = {1'b1, s.cur};
    end
    return r;
  endfunction

  function automatic logic dispatch_slot(inout sched_t s, input logic [FIELD_W-1:0] nx);
    logic resumed;
    resumed = 1'b0;
    if (s.st[s.cur] == ST_RUNNING) begin
      s.st[s.cur] = ST_READY;
    end
    s.st[nx] = ST_RUNNING;
    s.cur    = nx;
    if (s.parked[nx]) begin
      s.parked[nx] = 1'b0;
      s.wake[nx]   = 1'b0;
      resumed      = 1'b1;
    end
    return resumed;
  endfunction

  function automatic sched_out_t schedule_event(inout sched_t s, input logic [REQ_W-1:0] req,
                                                input logic [FIELD_W-1:0] tgt);
    sched_out_t         o;
    logic [FIELD_W-1:0] prev;
    logic [FIELD_W:0]   nx;
    logic               done;
    int                 k;
    o    = '0;
    prev = s.cur;
    done = 1'b0;
    if (!s.halt) begin
      case (req)
        REQ_TICK: begin
          if (s.ql != '0) begin
            s.ql = s.ql - 1'b1;
          end else begin
            s.ql = s.qticks;
            nx   = pick_next_ready(s);
            if (nx[FIELD_W] && nx[FIELD_W-1:0] != s.cur) begin
              o.resumed = dispatch_slot(s, nx[FIELD_W-1:0]);
            end
          end
        end
        REQ_YIELD: begin
          nx = pick_next_ready(s);
          if (nx[FIELD_W] && nx[FIELD_W-1:0] != s.cur) begin
            o.resumed = dispatch_slot(s, nx[FIELD_W-1:0]);
          end
        end
        REQ_BLOCK: begin
          if (s.wake[s.cur]) begin
            s.wake[s.cur] = 1'b0;
            o.consumed    = 1'b1;
          end else begin
            s.st[s.cur] = ST_BLOCKED;
            nx          = pick_next_ready(s);
            if (nx[FIELD_W]) begin
              s.parked[s.cur] = 1'b1;
              o.resumed       = dispatch_slot(s, nx[FIELD_W-1:0]);
            end else begin
              // nothing else runnable, thread keeps running
              s.st[s.cur]   = ST_RUNNING;
              s.wake[s.cur] = 1'b0;
            end
          end
        end
        REQ_WAKE: begin
          s.wake[tgt] = 1'b1;
          if (s.st[tgt] == ST_BLOCKED || s.st[tgt] == ST_SLEEPING) begin
            s.st[tgt] = ST_READY;
          end
        end
        REQ_EXIT: begin
          s.st[s.cur] = ST_UNUSED;
          nx          = pick_next_ready(s);
          if (!nx[FIELD_W]) begin
            s.halt = 1'b1;
          end else begin
            o.resumed = dispatch_slot(s, nx[FIELD_W-1:0]);
          end
        end
        REQ_CREATE: begin
          for (k = 0; k < SLOTS; k++) begin
            if (!done && s.st[k] == ST_UNUSED) begin
              s.st[k]     = ST_READY;
              s.wake[k]   = 1'b0;
              s.parked[k] = 1'b0;
              o.cok       = 1'b1;
              o.cslot     = FIELD_W'(k);
              o.cid       = s.next_id;
              s.next_id   = s.next_id + 1'b1;
              done        = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    o.running  = s.cur;
    o.switched = (s.cur != prev);
    o.previous = prev;
    o.halted   = s.halt;
    return o;
  endfunction

  function automatic string result_text(input sched_out_t r);
    return $sformatf("run=%0d sw=%0b prev=%0d resumed=%0b consumed=%0b cok=%0b cslot=%0d cid=%0d halt=%0b",
                     r.running, r.switched, r.previous, r.resumed, r.consumed, r.cok,
                     r.cslot, r.cid, r.halted);
  endfunction

  task automatic flag_error(input string msg);
    if (err_count < 10) begin
      $display("ERROR: %s", msg);
    end
    err_count++;
  endtask

  task automatic add_event(input logic [REQ_W-1:0] req, input logic [FIELD_W-1:0] tgt);
    event_t ev;
    ev.req = req;
    ev.tgt = tgt;
    void'(schedule_event(plan_state, req, tgt));
    pending_events.push_back(ev);
  endtask

  task automatic set_quantum(input logic [Q_W-1:0] q);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= q;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    table_state.qticks = q;
    plan_state.qticks  = q;
  endtask

  task automatic drain;
    while (pending_events.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // mostly live-thread traffic; exits that would halt become creates
  task automatic add_random(input int n);
    int                 i;
    int                 r;
    logic [FIELD_W:0]   b;
    sched_t             probe;
    logic [REQ_W-1:0]   req;
    logic [FIELD_W-1:0] tgt;
    for (i = 0; i < n; i++) begin
      r   = $urandom_range(99);
      tgt = FIELD_W'($urandom_range(SLOTS - 1));
      if (r < 22) begin
        req = REQ_TICK;
      end else if (r < 34) begin
        req = REQ_YIELD;
      end else if (r < 50) begin
        req = REQ_BLOCK;
      end else if (r < 70) begin
        req = REQ_WAKE;
        b   = scan_for_state(plan_state, ST_BLOCKED, $urandom_range(SLOTS - 1));
        if (b[FIELD_W] && $urandom_range(3) != 0) begin
          tgt = b[FIELD_W-1:0];
        end
      end else if (r < 82) begin
        req   = REQ_EXIT;
        probe = plan_state;
        void'(schedule_event(probe, REQ_EXIT, tgt));
        if (probe.halt) begin
          req = REQ_CREATE;
        end
      end else if (r < 96) begin
        req = REQ_CREATE;
      end else begin
        req = $urandom_range(1) ? REQ_RSVD6 : REQ_RSVD7;
      end
      add_event(req, tgt);
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      req_type_i    <= '0;
      target_slot_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(schedule_event(table_state, req_type_i, target_slot_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_word      = pending_events.pop_front();
          in_valid_i    <= 1'b1;
          req_type_i    <= next_word.req;
          target_slot_i <= next_word.tgt;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        seen_word = {running_slot_o, switched_o, previous_slot_o, resumed_from_block_o,
                     wake_consumed_o, create_ok_o, created_slot_o, created_id_o, halted_o};
        if (expected_results.size() == 0) begin
          flag_error($sformatf("result word with nothing expected: %s", result_text(seen_word)));
        end else begin
          want_word = expected_results.pop_front();
          n_results++;
          n_switch  += want_word.switched;
          n_resume  += want_word.resumed;
          n_consume += want_word.consumed;
          n_create  += want_word.cok;
          if (seen_word !== want_word) begin
            flag_error($sformatf("result %0d expected %s", n_results, result_text(want_word)));
            if (err_count <= 10) begin
              $display("       got      %s", result_text(seen_word));
            end
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin : stimulus
    logic [FIELD_W:0] b;
    sched_t           probe;
    int               p;
    table_state         = '0;
    table_state.st[0]   = ST_RUNNING;
    table_state.ql      = QUANTUM_RESET;
    table_state.next_id = ID_RESET;
    table_state.qticks  = QUANTUM_RESET;
    plan_state          = table_state;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed opening
    set_quantum(8'd1);
    add_event(REQ_BLOCK, 3'd0);   // nothing else runnable
    add_event(REQ_YIELD, 3'd0);   // nothing ready
    add_event(REQ_WAKE, 3'd5);    // unused slot
    add_event(REQ_CREATE, 3'd0);
    add_event(REQ_WAKE, 3'd0);    // running slot
    add_event(REQ_BLOCK, 3'd2);   // pending wake consumed
    add_event(REQ_TICK, 3'd0);
    add_event(REQ_TICK, 3'd0);
    add_event(REQ_TICK, 3'd0);    // quantum expired, rotate
    add_event(REQ_BLOCK, 3'd0);
    add_event(REQ_WAKE, 3'd1);    // blocked slot readied
    add_event(REQ_YIELD, 3'd7);   // resume inside block
    repeat (7) add_event(REQ_CREATE, 3'd6);  // last one finds table full
    add_event(REQ_RSVD6, 3'd2);
    add_event(REQ_RSVD7, 3'd5);
    add_event(REQ_EXIT, 3'd0);
    add_event(REQ_WAKE, 3'd7);
    drain();

    // random phases with varied quantum and channel pressure
    for (p = 0; p < 4; p++) begin
      case (p)
        0: set_quantum(8'd0);
        1: set_quantum(8'd255);
        2: set_quantum(Q_W'($urandom_range(1, 254)));
        default: set_quantum(8'd3);
      endcase
      send_idle_pct <= (p == 1) ? 68 : (p == 3) ? 10 : 0;
      stall_pct     <= (p == 2) ? 68 : (p == 3) ? 10 : 0;
      add_random(450);
      drain();
    end

    // create/exit churn over a filling and emptying slot table
    send_idle_pct <= 0;
    stall_pct     <= 0;
    set_quantum(QUANTUM_RESET);
    for (p = 0; p < 60; p++) begin
      b = scan_for_state(plan_state, ST_UNUSED, 0);
      if (b[FIELD_W]) begin
        add_event(REQ_CREATE, FIELD_W'($urandom_range(SLOTS - 1)));
      end else begin
        probe = plan_state;
        void'(schedule_event(probe, REQ_EXIT, '0));
        if (probe.halt) begin
          b = scan_for_state(plan_state, ST_BLOCKED, 0);
          add_event(REQ_WAKE, b[FIELD_W-1:0]);
        end else begin
          add_event(REQ_EXIT, FIELD_W'($urandom_range(SLOTS - 1)));
        end
      end
    end
    drain();

    // exit down to a halt, then events that must be ignored
    send_idle_pct <= 10;
    stall_pct     <= 10;
    while (!plan_state.halt) begin
      add_event(REQ_EXIT, FIELD_W'($urandom_range(SLOTS - 1)));
    end
    add_event(REQ_TICK, 3'd1);
    add_event(REQ_CREATE, 3'd0);
    add_event(REQ_WAKE, 3'd2);
    add_event(REQ_BLOCK, 3'd4);
    add_event(REQ_YIELD, 3'd7);
    add_event(REQ_RSVD7, 3'd3);
    drain();

    repeat (20) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      flag_error($sformatf("%0d result words never arrived", expected_results.size()));
    end
    $display("checked %0d result words under quantum 0, 1, 2, 3, 255 and a random value",
             n_results);
    $display("%0d switches, %0d resumes from block, %0d consumed wakes, %0d creates, %0d errors",
             n_switch, n_resume, n_consume, n_create, err_count);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
